// ===== rtl/ppp_pkg.sv =====
// Shared types, constants and helper functions of the partition path parser.
package ppp_pkg;

  localparam int MAX_COMPONENTS_DEF = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] KIND_DISK  = 3'd0;
  localparam logic [2:0] KIND_COMP  = 3'd1;
  localparam logic [2:0] KIND_QUERY = 3'd2;
  localparam logic [2:0] KIND_OK    = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_P_LOW   = 8'h70;
  localparam logic [7:0] CH_P_UP    = 8'h50;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_K       = 8'h6B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [5:0] {
    PH_LEAD     = 6'b000001,
    PH_DISKPFX  = 6'b000010,
    PH_DISKNUM  = 6'b000100,
    PH_COMPNUM  = 6'b001000,
    PH_QUERY    = 6'b010000,
    PH_SEGSTART = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  comp_index;
    logic        has_query;
    logic        final_res;
  } result_t;

  // Returns the expected letter of the "disk" prefix at a given position.
  function automatic logic [7:0] disk_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = CH_D;
      3'd1: ch = CH_I;
      3'd2: ch = CH_S;
      3'd3: ch = CH_K;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Returns a valid flag in the top bit and the nibble value below it.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/partition_path_parser.sv =====
// Partition path parser: one path byte per cycle in, item stream out through a small queue.
// An accepted byte's results are written into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while in_ready is high; the final byte may produce two results.
// The four-entry result queue holds back in_ready while fewer than two entries are free.
// Reset (rst_n low, synchronous) returns the parser to the leading-slash state and empties
// the queue; after each final byte the parse state returns to that same state.
module partition_path_parser #(
  parameter int MAX_COMPONENTS = ppp_pkg::MAX_COMPONENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_path,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic [2:0]  out_comp_index,
  output logic        out_has_query,
  output logic        out_final_res
);

  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);

  ppp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]       seg_pos_r, seg_pos_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             dseen_r, dseen_nxt;
  logic [1:0]       esc_r, esc_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       run_r, run_nxt;
  logic             first_r, first_nxt;
  logic             failed_r, failed_nxt;

  ppp_pkg::result_t fifo_r [ppp_pkg::FIFO_DEPTH];
  logic [ppp_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ppp_pkg::FIFO_CNT_W-1:0] fcnt_r;

  ppp_pkg::result_t e0, e1;
  logic             e0_v, e1_v;
  logic             in_acc, out_acc;
  logic             is_digit, acc_ovf, do_start, ok;
  logic [35:0]      acc10;
  logic [4:0]       hexv;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign in_ready = fcnt_r <= ppp_pkg::FIFO_CNT_W'(ppp_pkg::FIFO_DEPTH - 2);

  assign is_digit = in_char_in inside {[ppp_pkg::CH_ZERO:ppp_pkg::CH_NINE]};
  assign acc10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
               + {28'b0, in_char_in - ppp_pkg::CH_ZERO};
  assign acc_ovf = |acc10[35:32];
  assign hexv = ppp_pkg::hex_value(in_char_in);

  always_comb begin
    phase_nxt  = phase_r;
    seg_pos_nxt = seg_pos_r;
    acc_nxt    = acc_r;
    dseen_nxt  = dseen_r;
    esc_nxt    = esc_r;
    hi_nxt     = hi_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    first_nxt  = first_r;
    failed_nxt = failed_r;
    e0_v       = 1'b0;
    e1_v       = 1'b0;
    e0         = '0;
    e1         = '0;
    do_start   = 1'b0;
    ok         = 1'b0;

    if (!failed_r) begin
      if (in_char_in == ppp_pkg::CH_SLASH) begin
        case (phase_r)
          ppp_pkg::PH_LEAD: begin
          end
          ppp_pkg::PH_SEGSTART: begin
            if (run_r < 2'd2) run_nxt = run_r + 2'd1;
          end
          ppp_pkg::PH_DISKNUM: begin
            if (!dseen_r) begin
              failed_nxt = 1'b1;
            end else begin
              e0_v = 1'b1;
              e0.kind = ppp_pkg::KIND_DISK;
              e0.value = acc_r;
              phase_nxt = ppp_pkg::PH_SEGSTART;
              run_nxt = 2'd1;
            end
          end
          ppp_pkg::PH_COMPNUM: begin
            if (!(dseen_r && acc_r != 32'd0)) begin
              failed_nxt = 1'b1;
            end else begin
              e0_v = 1'b1;
              e0.kind = ppp_pkg::KIND_COMP;
              e0.value = acc_r;
              e0.comp_index = 3'(cnt_r);
              cnt_nxt = cnt_r + CNT_W'(1);
              phase_nxt = ppp_pkg::PH_SEGSTART;
              run_nxt = 2'd1;
            end
          end
          ppp_pkg::PH_QUERY: begin
            if (esc_r != 2'd0) begin
              failed_nxt = 1'b1;
            end else begin
              phase_nxt = ppp_pkg::PH_SEGSTART;
              run_nxt = 2'd1;
            end
          end
          default: failed_nxt = 1'b1;
        endcase
      end else begin
        case (phase_r)
          ppp_pkg::PH_SEGSTART: begin
            if (run_r >= 2'd2) failed_nxt = 1'b1;
            else do_start = 1'b1;
          end
          ppp_pkg::PH_LEAD: do_start = 1'b1;
          ppp_pkg::PH_DISKPFX: begin
            if (seg_pos_r < 3'd4 && in_char_in == ppp_pkg::disk_char(seg_pos_r)) begin
              seg_pos_nxt = seg_pos_r + 3'd1;
              if (seg_pos_r == 3'd3) begin
                phase_nxt = ppp_pkg::PH_DISKNUM;
                acc_nxt = 32'd0;
                dseen_nxt = 1'b0;
              end
            end else begin
              failed_nxt = 1'b1;
            end
          end
          ppp_pkg::PH_DISKNUM: begin
            if (!is_digit || acc_ovf) begin
              failed_nxt = 1'b1;
            end else begin
              acc_nxt = acc10[31:0];
              dseen_nxt = 1'b1;
            end
          end
          ppp_pkg::PH_COMPNUM: begin
            if (is_digit) begin
              if (acc_ovf) begin
                failed_nxt = 1'b1;
              end else begin
                acc_nxt = acc10[31:0];
                dseen_nxt = 1'b1;
              end
            end else if (in_char_in == ppp_pkg::CH_QUEST && dseen_r && acc_r != 32'd0) begin
              e0_v = 1'b1;
              e0.kind = ppp_pkg::KIND_COMP;
              e0.value = acc_r;
              e0.comp_index = 3'(cnt_r);
              e0.has_query = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
              phase_nxt = ppp_pkg::PH_QUERY;
              esc_nxt = 2'd0;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          ppp_pkg::PH_QUERY: begin
            if (esc_r == 2'd0) begin
              if (in_char_in == ppp_pkg::CH_PERCENT) begin
                esc_nxt = 2'd1;
              end else begin
                e0_v = 1'b1;
                e0.kind = ppp_pkg::KIND_QUERY;
                e0.value = {24'd0, in_char_in};
                e0.comp_index = 3'(cnt_r - CNT_W'(1));
              end
            end else if (!hexv[4]) begin
              failed_nxt = 1'b1;
            end else if (esc_r == 2'd1) begin
              hi_nxt = hexv[3:0];
              esc_nxt = 2'd2;
            end else begin
              e0_v = 1'b1;
              e0.kind = ppp_pkg::KIND_QUERY;
              e0.value = {24'd0, hi_r, hexv[3:0]};
              e0.comp_index = 3'(cnt_r - CNT_W'(1));
              esc_nxt = 2'd0;
            end
          end
          default: failed_nxt = 1'b1;
        endcase
      end

      if (do_start) begin
        if (first_r && in_char_in == ppp_pkg::CH_D) begin
          phase_nxt = ppp_pkg::PH_DISKPFX;
          seg_pos_nxt = 3'd1;
          first_nxt = 1'b0;
          run_nxt = 2'd0;
        end else if (in_char_in == ppp_pkg::CH_P_LOW || in_char_in == ppp_pkg::CH_P_UP) begin
          if (cnt_r >= CNT_W'(MAX_COMPONENTS)) begin
            failed_nxt = 1'b1;
          end else begin
            phase_nxt = ppp_pkg::PH_COMPNUM;
            acc_nxt = 32'd0;
            dseen_nxt = 1'b0;
            first_nxt = 1'b0;
            run_nxt = 2'd0;
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end

    if (in_end_of_path) begin
      ok = !failed_nxt;
      e1 = '0;
      e1.final_res = 1'b1;
      e1.kind = ppp_pkg::KIND_OK;
      case (phase_nxt)
        ppp_pkg::PH_SEGSTART: ok = ok && (cnt_nxt != CNT_W'(0));
        ppp_pkg::PH_COMPNUM: begin
          if (ok && dseen_nxt && acc_nxt != 32'd0) begin
            e0_v = 1'b1;
            e0 = '0;
            e0.kind = ppp_pkg::KIND_COMP;
            e0.value = acc_nxt;
            e0.comp_index = 3'(cnt_nxt);
          end else begin
            ok = 1'b0;
          end
        end
        ppp_pkg::PH_QUERY: ok = ok && (esc_nxt == 2'd0);
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        e0 = '0;
        e0.kind = ppp_pkg::KIND_ERROR;
        e0.final_res = 1'b1;
        e0_v = 1'b1;
        e1_v = 1'b0;
      end else if (e0_v) begin
        e1_v = 1'b1;
      end else begin
        e0 = e1;
        e0_v = 1'b1;
      end
      phase_nxt  = ppp_pkg::PH_LEAD;
      seg_pos_nxt = 3'd0;
      acc_nxt    = 32'd0;
      dseen_nxt  = 1'b0;
      esc_nxt    = 2'd0;
      hi_nxt     = 4'd0;
      cnt_nxt    = CNT_W'(0);
      run_nxt    = 2'd0;
      first_nxt  = 1'b1;
      failed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ppp_pkg::PH_LEAD;
      seg_pos_r <= 3'd0;
      acc_r    <= 32'd0;
      dseen_r  <= 1'b0;
      esc_r    <= 2'd0;
      hi_r     <= 4'd0;
      cnt_r    <= CNT_W'(0);
      run_r    <= 2'd0;
      first_r  <= 1'b1;
      failed_r <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      seg_pos_r <= seg_pos_nxt;
      acc_r    <= acc_nxt;
      dseen_r  <= dseen_nxt;
      esc_r    <= esc_nxt;
      hi_r     <= hi_nxt;
      cnt_r    <= cnt_nxt;
      run_r    <= run_nxt;
      first_r  <= first_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && e0_v) begin
      fifo_r[wr_ptr_r] <= e0;
    end
    if (in_acc && e1_v) begin
      fifo_r[wr_ptr_r + ppp_pkg::FIFO_PTR_W'(1)] <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ppp_pkg::FIFO_PTR_W'(in_acc && e0_v)
                           + ppp_pkg::FIFO_PTR_W'(in_acc && e1_v);
      rd_ptr_r <= rd_ptr_r + ppp_pkg::FIFO_PTR_W'(out_acc);
      fcnt_r   <= fcnt_r + ppp_pkg::FIFO_CNT_W'(in_acc && e0_v)
                         + ppp_pkg::FIFO_CNT_W'(in_acc && e1_v)
                         - ppp_pkg::FIFO_CNT_W'(out_acc);
    end
  end

  assign out_valid      = fcnt_r != '0;
  assign out_kind       = fifo_r[rd_ptr_r].kind;
  assign out_value      = fifo_r[rd_ptr_r].value;
  assign out_comp_index = fifo_r[rd_ptr_r].comp_index;
  assign out_has_query  = fifo_r[rd_ptr_r].has_query;
  assign out_final_res  = fifo_r[rd_ptr_r].final_res;

  // The queue never holds more entries than it has.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= ppp_pkg::FIFO_CNT_W'(ppp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // A final byte returns the parse state to its reset values.
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_path |=> phase_r == ppp_pkg::PH_LEAD && cnt_r == CNT_W'(0)
      && !failed_r && first_r)
    else $error("parse state not cleared after final byte");

  // After an error, a non-final byte produces no transaction.
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && failed_r && !in_end_of_path |-> !e0_v)
    else $error("result produced after parse error");

  // A second result in one cycle is always the closing status.
  a_second_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    e1_v |-> e0_v && e1.final_res && in_end_of_path)
    else $error("unexpected second result");

endmodule
